// File: rtl/record_checksum_hold_last_valid_assert.svh
// Assertion macros shared by the record checksum block.
`ifndef RECORD_CHECKSUM_HOLD_LAST_VALID_ASSERT_SVH
`define RECORD_CHECKSUM_HOLD_LAST_VALID_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCHK_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCHK_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: rtl/rchk_pkg.sv
// Types and constants of the record checksum block.
`default_nettype none

package rchk_pkg;

    localparam int RECORDS    = 128;
    localparam int REC_BYTES  = 10;
    localparam int DATA_BYTES = 8;

    localparam logic [3:0]  DATA_END    = 4'(DATA_BYTES);
    localparam logic [3:0]  LAST_POS    = 4'(REC_BYTES - 1);
    localparam logic [6:0]  LAST_RECORD = 7'(RECORDS - 1);
    localparam logic [10:0] PACKET_LEN  = 11'(RECORDS * REC_BYTES);

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_packet;
        logic [10:0] packet_length;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] record_data;
        logic        checksum_ok;
        logic [6:0]  record_index;
        logic        last_of_packet;
    } out_beat_t;

    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } rchk_result_t;

endpackage

`default_nettype wire

// File: rtl/rchk_assemble.sv
// Record assembly, word sum, checksum compare and last-valid hold.
`default_nettype none

module rchk_assemble (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire rchk_pkg::in_beat_t beat,
    output rchk_pkg::rchk_result_t result
);
    import rchk_pkg::*;

    logic [3:0]  byte_position_reg, byte_position_next;
    logic [6:0]  record_counter_reg, record_counter_next;
    logic [63:0] data_shift_reg, data_shift_next;
    logic [17:0] word_sum_reg, word_sum_next;
    logic [7:0]  low_byte_hold_reg, low_byte_hold_next;
    logic [63:0] last_valid_reg, last_valid_next;
    logic        dropping_reg, dropping_next;

    logic [3:0]  pos_eff;
    logic [6:0]  cnt_eff;
    logic [63:0] shift_eff;
    logic [17:0] sum_eff;
    logic [63:0] lv_eff;
    logic        drop_eff;
    logic [16:0] folded;
    logic [15:0] check;
    logic        ok;

    always_comb
    begin
        // A first byte restarts the packet before the byte itself is handled.
        if (beat.first_of_packet)
        begin
            pos_eff   = '0;
            cnt_eff   = '0;
            shift_eff = '0;
            sum_eff   = '0;
            lv_eff    = '0;
            drop_eff  = (beat.packet_length != PACKET_LEN);
        end
        else
        begin
            pos_eff   = byte_position_reg;
            cnt_eff   = record_counter_reg;
            shift_eff = data_shift_reg;
            sum_eff   = word_sum_reg;
            lv_eff    = last_valid_reg;
            drop_eff  = dropping_reg;
        end

        folded = {1'b0, sum_eff[15:0]} + {15'd0, sum_eff[17:16]};
        check  = {beat.data_byte, low_byte_hold_reg};
        ok     = (folded == {1'b0, check});

        byte_position_next  = pos_eff;
        record_counter_next = cnt_eff;
        data_shift_next     = shift_eff;
        word_sum_next       = sum_eff;
        low_byte_hold_next  = low_byte_hold_reg;
        last_valid_next     = lv_eff;
        dropping_next       = drop_eff;

        result.valid               = 1'b0;
        result.beat.record_data    = ok ? shift_eff : lv_eff;
        result.beat.checksum_ok    = ok;
        result.beat.record_index   = cnt_eff;
        result.beat.last_of_packet = (cnt_eff == LAST_RECORD);

        if (!drop_eff)
        begin
            if (pos_eff < DATA_END)
            begin
                data_shift_next = {beat.data_byte, shift_eff[63:8]};
                if (pos_eff[0])
                begin
                    word_sum_next = sum_eff + {2'b00, beat.data_byte, low_byte_hold_reg};
                end
                else
                begin
                    low_byte_hold_next = beat.data_byte;
                end
                byte_position_next = pos_eff + 4'd1;
            end
            else if (pos_eff == DATA_END)
            begin
                low_byte_hold_next = beat.data_byte;
                byte_position_next = pos_eff + 4'd1;
            end
            else
            begin
                result.valid = 1'b1;
                if (ok)
                begin
                    last_valid_next = shift_eff;
                end
                // Wrap the record count and drop the rest of the packet.
                if (cnt_eff == LAST_RECORD)
                begin
                    record_counter_next = '0;
                    dropping_next       = 1'b1;
                end
                else
                begin
                    record_counter_next = cnt_eff + 7'd1;
                end
                byte_position_next = '0;
                data_shift_next    = '0;
                word_sum_next      = '0;
            end
        end

        if (!accept)
        begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg  <= '0;
            record_counter_reg <= '0;
            data_shift_reg     <= '0;
            word_sum_reg       <= '0;
            low_byte_hold_reg  <= '0;
            last_valid_reg     <= '0;
            dropping_reg       <= 1'b0;
        end
        else if (accept)
        begin
            byte_position_reg  <= byte_position_next;
            record_counter_reg <= record_counter_next;
            data_shift_reg     <= data_shift_next;
            word_sum_reg       <= word_sum_next;
            low_byte_hold_reg  <= low_byte_hold_next;
            last_valid_reg     <= last_valid_next;
            dropping_reg       <= dropping_next;
        end
    end

`include "record_checksum_hold_last_valid_assert.svh"

    `RCHK_ASSERT_NOW(a_pos_range, 1'b1, byte_position_reg <= LAST_POS, "byte position out of range")
    `RCHK_ASSERT_NOW(a_result_at_check, result.valid, byte_position_reg == LAST_POS && !beat.first_of_packet, "result off checksum byte")
    `RCHK_ASSERT_NOW(a_drop_silent, dropping_reg && !beat.first_of_packet, !result.valid, "result while dropping")

endmodule

`default_nettype wire

// File: rtl/rchk_outbuf.sv
// Result register with a skid entry on the output channel.
`default_nettype none

module rchk_outbuf (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rchk_pkg::rchk_result_t result,
    output logic                       full,
    output logic                       record_valid,
    input  wire logic                  record_stall,
    output rchk_pkg::out_beat_t        record_beat
);
    import rchk_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_beat_t main_reg, main_next;
    out_beat_t skid_reg, skid_next;
    logic      take;

    assign take         = main_valid_reg && !record_stall;
    assign record_valid = main_valid_reg;
    assign record_beat  = main_reg;
    assign full         = skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // Upstream is held off, so only advance the skid entry.
            if (take)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (result.valid)
        begin
            if (main_valid_reg && !take)
            begin
                skid_next       = result.beat;
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_next       = result.beat;
                main_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

`include "record_checksum_hold_last_valid_assert.svh"

    `RCHK_ASSERT_NOW(a_skid_behind_main, skid_valid_reg, main_valid_reg, "skid full with main empty")
    `RCHK_ASSERT_NOW(a_skid_on_stall, $rose(skid_valid_reg), $past(main_valid_reg && record_stall), "skid filled without stall")
    `RCHK_ASSERT_NEXT(a_skid_hold, skid_valid_reg && record_stall, skid_valid_reg, "skid lost while stalled")
    `RCHK_ASSERT_NOW(a_no_result_when_full, skid_valid_reg, !result.valid, "result arrived with skid full")

endmodule

`default_nettype wire

// File: rtl/record_checksum_hold_last_valid.sv
// Top level of the record checksum block with last-valid substitution.
`default_nettype none

// Packet bytes arrive one beat per cycle on the byte channel. Each packet is
// a run of 128 records of ten bytes: eight data bytes, then a little-endian
// 16-bit checksum. The four little-endian data words are summed to 18 bits,
// the carry is folded back once, and the result is compared with the
// checksum. A passing record is sent and kept; a failing one is replaced by
// the last passing record of the same packet (zero if none yet) and sent with
// checksum_ok low. A packet whose length on its first byte is not 1280 gives
// no records, and bytes past the last record are ignored until the next first
// byte. Bytes before the first first-byte after reset count as a packet in
// progress. The block takes one byte per cycle while byte stall is low; a
// record beat is registered once its tenth byte is taken, into the output
// register, or the skid entry if the output is stalled. Byte stall rises only
// when a record waits stalled at the output and a second is in the skid entry.
module record_checksum_hold_last_valid (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire rchk_pkg::in_beat_t  byte_beat,
    output logic                     record_valid,
    input  wire logic                record_stall,
    output rchk_pkg::out_beat_t      record_beat
);
    import rchk_pkg::*;

    logic         accept;
    logic         full;
    rchk_result_t result;

    // Take a byte whenever the skid entry is free.
    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    // Hold record state and produce at most one result per accepted beat.
    rchk_assemble u_assemble (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (byte_beat),
        .result (result)
    );

    // Register the result and absorb one stalled beat.
    rchk_outbuf u_outbuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .full         (full),
        .record_valid (record_valid),
        .record_stall (record_stall),
        .record_beat  (record_beat)
    );

endmodule

`default_nettype wire
